// File: hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, register indexes, result codes and the saturation helper for
// the particle/plane collision pipeline.
// ----------------------------------------------------------------------------
package ppc_pkg;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_NORMAL_X          = 3'd0;
    localparam cfg_idx_t REG_NORMAL_Y          = 3'd1;
    localparam cfg_idx_t REG_NORMAL_Z          = 3'd2;
    localparam cfg_idx_t REG_PLANE_OFFSET      = 3'd3;
    localparam cfg_idx_t REG_PLANE_RESTITUTION = 3'd4;
    localparam cfg_idx_t REG_EPSILON           = 3'd5;
    localparam cfg_idx_t REG_CONTACT_THRESHOLD = 3'd6;

    typedef logic [1:0] outcome_t;

    localparam outcome_t OUTCOME_NONE    = 2'd0;
    localparam outcome_t OUTCOME_BOUNCE  = 2'd1;
    localparam outcome_t OUTCOME_CONTACT = 2'd2;

    localparam logic CMD_BOUNCE  = 1'b0;
    localparam logic CMD_CONTACT = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic        [16:0] particle_restitution;
    } ppc_in_t;

    typedef struct packed {
        outcome_t           outcome;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] reaction_x;
        logic signed [31:0] reaction_y;
        logic signed [31:0] reaction_z;
    } ppc_out_t;

    // clamp to the 32 bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        logic signed [31:0] r;
        if (a > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (a < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = a[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ppc_in_if.sv
// ----------------------------------------------------------------------------
// ppc_in_if
// Valid/ready channel carrying one particle word and its command.
// ----------------------------------------------------------------------------
interface ppc_in_if
    import ppc_pkg::*;
();
    logic    valid;
    logic    ready;
    ppc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ppc_out_if.sv
// ----------------------------------------------------------------------------
// ppc_out_if
// Valid/ready channel carrying one collision result word.
// ----------------------------------------------------------------------------
interface ppc_out_if
    import ppc_pkg::*;
();
    logic     valid;
    logic     ready;
    ppc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/particle_plane_collision.sv
// ----------------------------------------------------------------------------
// particle_plane_collision
// Bounce and resting-contact response of one particle against a plane,
// Q16.16 fixed point with saturated results, seven-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  item      in   valid/ready      ppc_in_t  (command, position, velocity,
//                                             force, particle restitution)
//  result    out  valid/ready      ppc_out_t (outcome, position, velocity,
//                                             reaction)
//  cfg       in   cfg_we only      cfg_index, cfg_data
//
//  One word enters per cycle while the sink takes words.
//  The rate is set by the widest multiply (18x38 and 32x32 products); the
//  multipliers sit in stages 1, 3, 4 and 6, each with a register after it.
//  Reset clears the stage valid bits and loads the plane registers.
//  A stalled result holds every stage; item.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module particle_plane_collision
    import ppc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ppc_in_if.sink          item,
    ppc_out_if.source       result,
    input  logic            cfg_we,
    input  cfg_idx_t        cfg_index,
    input  logic [31:0]     cfg_data
);

    // ---------------- configuration ----------------
    logic signed [17:0] normal_reg [3];
    logic signed [31:0] offset_reg;
    logic        [16:0] plane_rest_reg;
    logic        [15:0] eps_reg;
    logic        [30:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0]  <= 18'sd0;
            normal_reg[1]  <= 18'sd65536;
            normal_reg[2]  <= 18'sd0;
            offset_reg     <= 32'sd0;
            plane_rest_reg <= 17'd65536;
            eps_reg        <= 16'd1;
            thr_reg        <= 31'd655;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NORMAL_X:          normal_reg[0]  <= cfg_data[17:0];
                REG_NORMAL_Y:          normal_reg[1]  <= cfg_data[17:0];
                REG_NORMAL_Z:          normal_reg[2]  <= cfg_data[17:0];
                REG_PLANE_OFFSET:      offset_reg     <= cfg_data;
                REG_PLANE_RESTITUTION: plane_rest_reg <= cfg_data[16:0];
                REG_EPSILON:           eps_reg        <= cfg_data[15:0];
                REG_CONTACT_THRESHOLD: thr_reg        <= cfg_data[30:0];
                default:               ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic       adv;
    logic [7:1] valid_reg;

    assign adv         = !valid_reg[7] || result.ready;
    assign item.ready  = adv;
    assign result.valid = valid_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[6:1], item.valid};
        end
    end

    // ---------------- stage 1: dot product terms, squares ----------------
    logic signed [31:0] pos_in [3];
    logic signed [31:0] vel_in [3];
    logic signed [31:0] frc_in [3];

    assign pos_in[0] = item.data.pos_x;
    assign pos_in[1] = item.data.pos_y;
    assign pos_in[2] = item.data.pos_z;
    assign vel_in[0] = item.data.vel_x;
    assign vel_in[1] = item.data.vel_y;
    assign vel_in[2] = item.data.vel_z;
    assign frc_in[0] = item.data.force_x;
    assign frc_in[1] = item.data.force_y;
    assign frc_in[2] = item.data.force_z;

    logic signed [49:0] nx_s1_next [3];
    logic signed [49:0] nv_s1_next [3];
    logic signed [49:0] nf_s1_next [3];
    logic        [63:0] vsq_s1_next [3];
    logic        [33:0] kprod_s1_next;
    logic        [31:0] vabs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vabs[i]        = vel_in[i][31] ? (~vel_in[i] + 32'd1) : vel_in[i];
            nx_s1_next[i]  = 50'(normal_reg[i]) * 50'(pos_in[i]);
            nv_s1_next[i]  = 50'(normal_reg[i]) * 50'(vel_in[i]);
            nf_s1_next[i]  = 50'(normal_reg[i]) * 50'(frc_in[i]);
            vsq_s1_next[i] = 64'(vabs[i]) * 64'(vabs[i]);
        end
        kprod_s1_next = 34'(plane_rest_reg) * 34'(item.data.particle_restitution);
    end

    logic signed [49:0] nx_s1_reg [3];
    logic signed [49:0] nv_s1_reg [3];
    logic signed [49:0] nf_s1_reg [3];
    logic        [63:0] vsq_s1_reg [3];
    logic        [33:0] kprod_s1_reg;
    ppc_in_t            item_s1_reg;

    // ---------------- stage 2: sums ----------------
    logic signed [53:0] dis_s2_next;
    logic signed [51:0] nv_s2_next;
    logic signed [51:0] fn_s2_next;
    logic        [63:0] vv_s2_next;
    logic        [18:0] k16_s2_next;
    logic        [34:0] ksum;

    always_comb
    begin
        dis_s2_next = 54'(nx_s1_reg[0]) + 54'(nx_s1_reg[1]) + 54'(nx_s1_reg[2])
                    - $signed({{6{offset_reg[31]}}, offset_reg, 16'h0000});
        nv_s2_next  = 52'(nv_s1_reg[0]) + 52'(nv_s1_reg[1]) + 52'(nv_s1_reg[2]);
        fn_s2_next  = 52'(nf_s1_reg[0]) + 52'(nf_s1_reg[1]) + 52'(nf_s1_reg[2]);
        vv_s2_next  = vsq_s1_reg[0] + vsq_s1_reg[1] + vsq_s1_reg[2];
        ksum        = 35'(kprod_s1_reg) + 35'd32768;
        k16_s2_next = ksum[34:16];
    end

    logic signed [53:0] dis_s2_reg;
    logic signed [51:0] nv_s2_reg;
    logic signed [51:0] fn_s2_reg;
    logic        [63:0] vv_s2_reg;
    logic        [18:0] k16_s2_reg;
    ppc_in_t            item_s2_reg;

    // ---------------- stage 3: rounding, tests ----------------
    logic signed [53:0] dis_rnd;
    logic signed [51:0] nv_rnd;
    logic signed [51:0] fn_rnd;
    logic signed [51:0] nv_neg;
    logic signed [37:0] dis16_s3_next;
    logic signed [35:0] nv16_s3_next;
    logic signed [35:0] fn16_s3_next;
    logic        [49:0] anv_s3_next;
    logic        [31:0] eps2_s3_next;
    logic               dis_lt_s3_next;
    logic               near_s3_next;

    always_comb
    begin
        dis_rnd        = dis_s2_reg + 54'sd32768;
        nv_rnd         = nv_s2_reg + 52'sd32768;
        fn_rnd         = fn_s2_reg + 52'sd32768;
        dis16_s3_next  = dis_rnd[53:16];
        nv16_s3_next   = nv_rnd[51:16];
        fn16_s3_next   = fn_rnd[51:16];
        nv_neg         = -nv_s2_reg;
        anv_s3_next    = nv_s2_reg[51] ? nv_neg[49:0] : nv_s2_reg[49:0];
        eps2_s3_next   = 32'(eps_reg) * 32'(eps_reg);
        dis_lt_s3_next = dis_s2_reg < $signed({22'h0, eps_reg, 16'h0000});
        near_s3_next   = anv_s3_next < {3'b000, thr_reg, 16'h0000};
    end

    logic signed [37:0] dis16_s3_reg;
    logic signed [35:0] nv16_s3_reg;
    logic signed [35:0] fn16_s3_reg;
    logic        [49:0] anv_s3_reg;
    logic        [31:0] eps2_s3_reg;
    logic        [63:0] vv_s3_reg;
    logic        [18:0] k16_s3_reg;
    logic               dis_lt_s3_reg;
    logic               near_s3_reg;
    logic               nvneg_s3_reg;
    logic               fneg_s3_reg;
    ppc_in_t            item_s3_reg;

    // ---------------- stage 4: products ----------------
    logic signed [53:0] vnp_s4_next [3];
    logic signed [55:0] pp_s4_next [3];
    logic signed [53:0] rp_s4_next [3];
    logic        [49:0] hh_s4_next;
    logic        [49:0] hl_s4_next;
    logic        [49:0] ll_s4_next;
    logic        [63:0] evh_s4_next;
    logic        [63:0] evl_s4_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vnp_s4_next[i] = 54'(normal_reg[i]) * 54'(nv16_s3_reg);
            pp_s4_next[i]  = 56'(normal_reg[i]) * 56'(dis16_s3_reg);
            rp_s4_next[i]  = 54'(normal_reg[i]) * 54'(fn16_s3_reg);
        end
        hh_s4_next  = 50'(anv_s3_reg[49:25]) * 50'(anv_s3_reg[49:25]);
        hl_s4_next  = 50'(anv_s3_reg[49:25]) * 50'(anv_s3_reg[24:0]);
        ll_s4_next  = 50'(anv_s3_reg[24:0]) * 50'(anv_s3_reg[24:0]);
        evh_s4_next = 64'(eps2_s3_reg) * 64'(vv_s3_reg[63:32]);
        evl_s4_next = 64'(eps2_s3_reg) * 64'(vv_s3_reg[31:0]);
    end

    logic signed [53:0] vnp_s4_reg [3];
    logic signed [55:0] pp_s4_reg [3];
    logic signed [53:0] rp_s4_reg [3];
    logic        [49:0] hh_s4_reg;
    logic        [49:0] hl_s4_reg;
    logic        [49:0] ll_s4_reg;
    logic        [63:0] evh_s4_reg;
    logic        [63:0] evl_s4_reg;
    logic        [18:0] k16_s4_reg;
    logic               dis_lt_s4_reg;
    logic               near_s4_reg;
    logic               nvneg_s4_reg;
    logic               fneg_s4_reg;
    logic               vvnz_s4_reg;
    ppc_in_t            item_s4_reg;

    // ---------------- stage 5: round products, approach test ----------------
    logic signed [53:0] vn_rnd [3];
    logic signed [55:0] p_rnd [3];
    logic signed [54:0] r_rnd [3];
    logic signed [37:0] vn_s5_next [3];
    logic signed [39:0] p_s5_next [3];
    logic signed [31:0] react_s5_next [3];
    logic        [99:0] a2;
    logic        [95:0] e2;
    logic               go_s5_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vn_rnd[i]        = vnp_s4_reg[i] + 54'sd32768;
            p_rnd[i]         = pp_s4_reg[i] + 56'sd32768;
            r_rnd[i]         = 55'sd32768 - 55'(rp_s4_reg[i]);
            vn_s5_next[i]    = vn_rnd[i][53:16];
            p_s5_next[i]     = p_rnd[i][55:16];
            react_s5_next[i] = fneg_s4_reg ? sat32(64'($signed(r_rnd[i][54:16])))
                                           : 32'sd0;
        end
        a2 = (100'(hh_s4_reg) << 50) + (100'(hl_s4_reg) << 26) + 100'(ll_s4_reg);
        e2 = (96'(evh_s4_reg) << 32) + 96'(evl_s4_reg);
        go_s5_next = nvneg_s4_reg && vvnz_s4_reg && (a2 > 100'(e2));
    end

    logic signed [37:0] vn_s5_reg [3];
    logic signed [39:0] p_s5_reg [3];
    logic signed [31:0] react_s5_reg [3];
    logic        [18:0] k16_s5_reg;
    logic               dis_lt_s5_reg;
    logic               near_s5_reg;
    logic               go_s5_reg;
    ppc_in_t            item_s5_reg;

    // ---------------- stage 6: restitution product, projection ----------------
    logic signed [31:0] pos_s5 [3];
    logic signed [31:0] vel_s5 [3];

    assign pos_s5[0] = item_s5_reg.pos_x;
    assign pos_s5[1] = item_s5_reg.pos_y;
    assign pos_s5[2] = item_s5_reg.pos_z;
    assign vel_s5[0] = item_s5_reg.vel_x;
    assign vel_s5[1] = item_s5_reg.vel_y;
    assign vel_s5[2] = item_s5_reg.vel_z;

    logic signed [57:0] vk_s6_next [3];
    logic signed [38:0] vmv_s6_next [3];
    logic signed [31:0] npos_s6_next [3];
    outcome_t           outcome_s6_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vk_s6_next[i]   = 58'(vn_s5_reg[i]) * 58'($signed({1'b0, k16_s5_reg}));
            vmv_s6_next[i]  = 39'(vel_s5[i]) - 39'(vn_s5_reg[i]);
            npos_s6_next[i] = sat32(64'(pos_s5[i]) - 64'(p_s5_reg[i]));
        end
        outcome_s6_next = OUTCOME_NONE;
        if (dis_lt_s5_reg)
        begin
            if (item_s5_reg.command == CMD_BOUNCE)
            begin
                if (go_s5_reg)
                begin
                    outcome_s6_next = OUTCOME_BOUNCE;
                end
            end
            else if (near_s5_reg)
            begin
                outcome_s6_next = OUTCOME_CONTACT;
            end
        end
    end

    logic signed [57:0] vk_s6_reg [3];
    logic signed [38:0] vmv_s6_reg [3];
    logic signed [31:0] npos_s6_reg [3];
    logic signed [31:0] react_s6_reg [3];
    outcome_t           outcome_s6_reg;
    ppc_in_t            item_s6_reg;

    // ---------------- stage 7: select and saturate ----------------
    logic signed [57:0] vk_rnd [3];
    logic signed [42:0] vb [3];
    logic signed [31:0] opos [3];
    logic signed [31:0] ovel [3];
    logic signed [31:0] orea [3];
    logic signed [31:0] pos_s6 [3];
    logic signed [31:0] vel_s6 [3];
    ppc_out_t           out_next;

    assign pos_s6[0] = item_s6_reg.pos_x;
    assign pos_s6[1] = item_s6_reg.pos_y;
    assign pos_s6[2] = item_s6_reg.pos_z;
    assign vel_s6[0] = item_s6_reg.vel_x;
    assign vel_s6[1] = item_s6_reg.vel_y;
    assign vel_s6[2] = item_s6_reg.vel_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vk_rnd[i] = vk_s6_reg[i] + 58'sd32768;
            vb[i]     = 43'(vmv_s6_reg[i]) - 43'($signed(vk_rnd[i][57:16]));
            case (outcome_s6_reg)
                OUTCOME_BOUNCE:
                begin
                    opos[i] = npos_s6_reg[i];
                    ovel[i] = sat32(64'(vb[i]));
                    orea[i] = 32'sd0;
                end
                OUTCOME_CONTACT:
                begin
                    opos[i] = npos_s6_reg[i];
                    ovel[i] = sat32(64'(vmv_s6_reg[i]));
                    orea[i] = react_s6_reg[i];
                end
                default:
                begin
                    opos[i] = pos_s6[i];
                    ovel[i] = vel_s6[i];
                    orea[i] = 32'sd0;
                end
            endcase
        end
        out_next.outcome    = outcome_s6_reg;
        out_next.new_pos_x  = opos[0];
        out_next.new_pos_y  = opos[1];
        out_next.new_pos_z  = opos[2];
        out_next.new_vel_x  = ovel[0];
        out_next.new_vel_y  = ovel[1];
        out_next.new_vel_z  = ovel[2];
        out_next.reaction_x = orea[0];
        out_next.reaction_y = orea[1];
        out_next.reaction_z = orea[2];
    end

    ppc_out_t out_reg;

    assign result.data = out_reg;

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nx_s1_reg[i]    <= nx_s1_next[i];
                nv_s1_reg[i]    <= nv_s1_next[i];
                nf_s1_reg[i]    <= nf_s1_next[i];
                vsq_s1_reg[i]   <= vsq_s1_next[i];
                vnp_s4_reg[i]   <= vnp_s4_next[i];
                pp_s4_reg[i]    <= pp_s4_next[i];
                rp_s4_reg[i]    <= rp_s4_next[i];
                vn_s5_reg[i]    <= vn_s5_next[i];
                p_s5_reg[i]     <= p_s5_next[i];
                react_s5_reg[i] <= react_s5_next[i];
                vk_s6_reg[i]    <= vk_s6_next[i];
                vmv_s6_reg[i]   <= vmv_s6_next[i];
                npos_s6_reg[i]  <= npos_s6_next[i];
                react_s6_reg[i] <= react_s5_reg[i];
            end
            kprod_s1_reg   <= kprod_s1_next;
            item_s1_reg    <= item.data;

            dis_s2_reg     <= dis_s2_next;
            nv_s2_reg      <= nv_s2_next;
            fn_s2_reg      <= fn_s2_next;
            vv_s2_reg      <= vv_s2_next;
            k16_s2_reg     <= k16_s2_next;
            item_s2_reg    <= item_s1_reg;

            dis16_s3_reg   <= dis16_s3_next;
            nv16_s3_reg    <= nv16_s3_next;
            fn16_s3_reg    <= fn16_s3_next;
            anv_s3_reg     <= anv_s3_next;
            eps2_s3_reg    <= eps2_s3_next;
            vv_s3_reg      <= vv_s2_reg;
            k16_s3_reg     <= k16_s2_reg;
            dis_lt_s3_reg  <= dis_lt_s3_next;
            near_s3_reg    <= near_s3_next;
            nvneg_s3_reg   <= nv_s2_reg[51];
            fneg_s3_reg    <= fn_s2_reg[51];
            item_s3_reg    <= item_s2_reg;

            hh_s4_reg      <= hh_s4_next;
            hl_s4_reg      <= hl_s4_next;
            ll_s4_reg      <= ll_s4_next;
            evh_s4_reg     <= evh_s4_next;
            evl_s4_reg     <= evl_s4_next;
            k16_s4_reg     <= k16_s3_reg;
            dis_lt_s4_reg  <= dis_lt_s3_reg;
            near_s4_reg    <= near_s3_reg;
            nvneg_s4_reg   <= nvneg_s3_reg;
            fneg_s4_reg    <= fneg_s3_reg;
            vvnz_s4_reg    <= (vv_s3_reg != 64'd0);
            item_s4_reg    <= item_s3_reg;

            k16_s5_reg     <= k16_s4_reg;
            dis_lt_s5_reg  <= dis_lt_s4_reg;
            near_s5_reg    <= near_s4_reg;
            go_s5_reg      <= go_s5_next;
            item_s5_reg    <= item_s4_reg;

            outcome_s6_reg <= outcome_s6_next;
            item_s6_reg    <= item_s5_reg;

            out_reg        <= out_next;
        end
    end

    // ---------------- assertions ----------------
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.outcome == OUTCOME_NONE ||
                          result.data.outcome == OUTCOME_BOUNCE ||
                          result.data.outcome == OUTCOME_CONTACT))
        else $error("illegal outcome code on result");

    a_bounce_no_reaction: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.outcome == OUTCOME_BOUNCE) |->
        (result.data.reaction_x == 32'sd0 && result.data.reaction_y == 32'sd0 &&
         result.data.reaction_z == 32'sd0))
        else $error("bounce result carries a reaction force");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> valid_reg[1])
        else $error("accepted word did not enter stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

endmodule
